// ===== src/modinv_pkg.sv =====
// Shared constants and controller/datapath interface types for the modular
// inverse core. No dependencies.
package modinv_pkg;

  // Field and datapath widths
  localparam int FIELD_W      = 63;
  localparam int COEF_W       = 64;
  localparam int SHIFT_W      = 6;
  localparam int OPERAND_BITS = 63;

  // Only the low OPERAND_BITS bits of each operand take part
  localparam logic [FIELD_W-1:0] OPERAND_MASK =
    FIELD_W'((65'(1) << OPERAND_BITS) - 65'(1));

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;     // capture a new item and set up the first round
    logic grow;     // double the aligned divisor
    logic shrink;   // one restoring-subtract step of the current round
    logic finish;   // normalize the coefficient and register the result
  } modinv_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic mod_zero;   // incoming modulus is zero
    logic grow_ok;    // doubled divisor still fits under the remainder
    logic k_zero;     // alignment shift is back at zero
    logic rem_zero;   // remainder of this round is zero
  } modinv_stat_t;

endpackage

// ===== src/modular_inverse_ext_euclid_core.sv =====
// Channel  | handshake                   | payload
// ---------+-----------------------------+--------------------------------------
// input    | start & !busy accepts       | value[62:0], modulus[62:0]
// result   | done, one cycle, no stall   | inverse[62:0], common_divisor[62:0],
//          |                             | coprime
//
// One item at a time. The shift-subtract quotient unit works each Euclid round
// in two phases: it first aligns the divisor, doubling it while it still fits
// under the remainder, then subtracts it back down one shift at a time. A zero
// modulus skips the rounds. done rises in the cycle after the finishing step,
// with busy falling. rst is synchronous and clears the controller and the
// strobe; the receiver cannot stall.
//
// Top level of the modular inverse core; depends on modinv_pkg,
// modinv_ctrl and modinv_dp.
module modular_inverse_ext_euclid_core
  import modinv_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [FIELD_W-1:0] value,
  input  logic [FIELD_W-1:0] modulus,
  output logic               done,
  output logic [FIELD_W-1:0] inverse,
  output logic [FIELD_W-1:0] common_divisor,
  output logic               coprime
);

  modinv_cmd_t  cmd;
  modinv_stat_t stat;

  modinv_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  modinv_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .value          (value),
    .modulus        (modulus),
    .stat           (stat),
    .done           (done),
    .inverse        (inverse),
    .common_divisor (common_divisor),
    .coprime        (coprime)
  );

endmodule

// ===== src/modinv_ctrl.sv =====
// Controller state machine of the modular inverse core.
// Depends on modinv_pkg for the command and status types.
module modinv_ctrl
  import modinv_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  modinv_stat_t stat,
  output modinv_cmd_t  cmd,
  output logic         busy
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_GROW   = 4'b0010,
    ST_SHRINK = 4'b0100,
    ST_FIX    = 4'b1000
  } state_t;

  state_t state, state_next;

  // Decode commands and next state
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = stat.mod_zero ? ST_FIX : ST_GROW;
        end
      end
      ST_GROW: begin
        if (stat.grow_ok) begin
          cmd.grow = 1'b1;
        end else begin
          state_next = ST_SHRINK;
        end
      end
      ST_SHRINK: begin
        cmd.shrink = 1'b1;
        if (stat.k_zero) begin
          state_next = stat.rem_zero ? ST_FIX : ST_GROW;
        end
      end
      ST_FIX: begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

// ===== src/modinv_dp.sv =====
// Datapath of the modular inverse core: remainder and coefficient registers,
// shift-subtract quotient unit and final normalization.
// Depends on modinv_pkg for widths and the command and status types.
module modinv_dp
  import modinv_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  modinv_cmd_t        cmd,
  input  logic [FIELD_W-1:0] value,
  input  logic [FIELD_W-1:0] modulus,
  output modinv_stat_t       stat,
  output logic               done,
  output logic [FIELD_W-1:0] inverse,
  output logic [FIELD_W-1:0] common_divisor,
  output logic               coprime
);

  logic [FIELD_W-1:0] a_in, m_in;
  logic [FIELD_W-1:0] m_reg;
  logic [FIELD_W-1:0] rp, rc;      // remainder pair
  logic [COEF_W-1:0]  sp, sc;      // coefficient pair, wrapping
  logic [FIELD_W-1:0] rem;         // running remainder of this round
  logic [COEF_W-1:0]  coef;        // running coefficient of this round
  logic [FIELD_W-1:0] dvs;         // divisor shifted left by k
  logic [SHIFT_W-1:0] k;

  logic [FIELD_W-1:0] dvs_dbl;
  logic [COEF_W-1:0]  sc_shl;
  logic               sub_ok;
  logic [FIELD_W-1:0] rem_new;
  logic [COEF_W-1:0]  coef_new;

  logic [COEF_W-1:0]  m_ext, coef_add, coef_sub;
  logic               m_small, coef_ge;
  logic [FIELD_W-1:0] inv_norm;

  assign a_in = value & OPERAND_MASK;
  assign m_in = modulus & OPERAND_MASK;

  // Quotient step: compare, subtract shifted divisor and shifted coefficient
  assign dvs_dbl  = {dvs[FIELD_W-2:0], 1'b0};
  assign sc_shl   = sc << k;
  assign sub_ok   = (rem >= dvs);
  assign rem_new  = sub_ok ? (rem - dvs) : rem;
  assign coef_new = sub_ok ? (coef - sc_shl) : coef;

  assign stat.mod_zero = (m_in == '0);
  assign stat.grow_ok  = !dvs[FIELD_W-1] && (dvs_dbl <= rem);
  assign stat.k_zero   = (k == '0);
  assign stat.rem_zero = (rem_new == '0);

  // Bring the coefficient into 0..modulus-1; its magnitude is at most modulus
  assign m_ext    = {1'b0, m_reg};
  assign coef_add = sp + m_ext;
  assign coef_sub = sp - m_ext;
  assign coef_ge  = (sp >= m_ext);
  assign m_small  = (m_reg[FIELD_W-1:1] == '0);
  always_comb begin
    if (sp[COEF_W-1]) begin
      inv_norm = coef_add[FIELD_W-1:0];
    end else if (coef_ge) begin
      inv_norm = coef_sub[FIELD_W-1:0];
    end else begin
      inv_norm = sp[FIELD_W-1:0];
    end
  end

  // Update working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_reg <= m_in;
      rp    <= a_in;
      rc    <= m_in;
      sp    <= COEF_W'(1);
      sc    <= '0;
      rem   <= a_in;
      coef  <= COEF_W'(1);
      dvs   <= m_in;
      k     <= '0;
    end else if (cmd.grow) begin
      dvs <= dvs_dbl;
      k   <= k + SHIFT_W'(1);
    end else if (cmd.shrink) begin
      if (k == '0) begin
        // Close the round and set up the next one
        rp   <= rc;
        rc   <= rem_new;
        sp   <= sc;
        sc   <= coef_new;
        rem  <= rc;
        coef <= sc;
        dvs  <= rem_new;
      end else begin
        rem  <= rem_new;
        coef <= coef_new;
        dvs  <= {1'b0, dvs[FIELD_W-1:1]};
        k    <= k - SHIFT_W'(1);
      end
    end
  end

  // Register the result
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      common_divisor <= rp;
      coprime        <= (rp == FIELD_W'(1));
      inverse        <= ((rp == FIELD_W'(1)) && !m_small) ? inv_norm : '0;
    end
  end

  // Strobe the result for one cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

endmodule

// ===== src/modinv_chk.sv =====
// Port-level checker for the modular inverse core, bound to the top level.
// Depends on modinv_pkg for field widths.
module modinv_chk
  import modinv_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [FIELD_W-1:0] inverse,
  input logic [FIELD_W-1:0] common_divisor,
  input logic               coprime
);

  // An accepted item makes the core busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // Busy drops only with a result, and no result is shown while busy
  a_done_on_fall: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("busy fell without a result");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while busy");

  // Coprime means a divisor of one
  a_coprime_gcd: assert property (@(posedge clk) disable iff (rst)
    (done && coprime) |-> (common_divisor == FIELD_W'(1)))
    else $error("coprime set with divisor other than one");

  // No inverse without coprimality
  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !coprime) |-> (inverse == '0))
    else $error("nonzero inverse for a non-coprime item");

endmodule

bind modular_inverse_ext_euclid_core modinv_chk u_chk (
  .clk            (clk),
  .rst            (rst),
  .start          (start),
  .busy           (busy),
  .done           (done),
  .inverse        (inverse),
  .common_divisor (common_divisor),
  .coprime        (coprime)
);
